@@ rtl/core/rxrb_pkg.sv @@
// rxrb_pkg: shared types and constants for the receive byte ring buffer
// no dependencies
package rxrb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned FLAG_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_OVERRUN = 2'd2
  } rxrb_func_e;

  // bit positions in the result tuser
  localparam int unsigned FLAG_VALID = 0;
  localparam int unsigned FLAG_OVER  = 1;

endpackage

@@ rtl/core/rxrb_ram.sv @@
// rxrb_ram: generic single-port synchronous ram with registered read
// no dependencies
module rxrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

@@ rtl/core/rx_byte_ring_buffer_overwrite.sv @@
// rx_byte_ring_buffer_overwrite: overwrite-oldest receive byte ring buffer
// depends on rxrb_pkg and rxrb_ram
//
// channel  dir  tdata (low bit up)                                  tuser
// s_axis   in   rx_byte                                             func
// m_axis   out  data_byte, fill_level, overrun_errors,               data_valid, overflowed
//               overflow_events, max_fill
//
// one request per cycle while m_axis does not stall; its result is offered on m_axis
// after the ram read at the accepting edge and then the output register
// reset clears indexes, fill, peak, counters and both valid stages; the byte
// store needs no clearing since a pop only reaches written entries
// while m_axis_tready is low one more request is taken into the ram read
// stage, then s_axis_tready drops
module rx_byte_ring_buffer_overwrite #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned LVL_W = $clog2(DEPTH + 1),
  localparam int unsigned M_TDATA_W =
    ((rxrb_pkg::BYTE_W + 2 * rxrb_pkg::CNT_W + 2 * LVL_W + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // rx_byte
  input  logic [rxrb_pkg::FUNC_W-1:0]  s_axis_tuser,   // func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // data_byte, fill_level, overrun_errors, overflow_events, max_fill
  output logic [M_TDATA_W-1:0]         m_axis_tdata,
  output logic [rxrb_pkg::FLAG_W-1:0]  m_axis_tuser    // data_valid, overflowed
);
  import rxrb_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned PACK_W = BYTE_W + 2 * CNT_W + 2 * LVL_W;

  logic [IW-1:0]    wr_idx_q, wr_idx_d;
  logic [LVL_W-1:0] fill_q, fill_d, peak_q, peak_d, fill_cut;
  logic [CNT_W-1:0] ovr_q, ovr_d, ovf_q, ovf_d;
  logic [IW:0]      wr_ext, cut_ext, rd_ext;

  logic             s_acc, pop_ok, over;
  logic             ram_en, ram_we;
  logic [IW-1:0]    ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  logic             s1_valid_q, s1_pop_q, s1_over_q, s1_move;
  logic [LVL_W-1:0] s1_fill_q, s1_peak_q;
  logic [CNT_W-1:0] s1_ovr_q, s1_ovf_q;

  logic             out_valid_q, out_pop_q, out_over_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [LVL_W-1:0] out_fill_q, out_peak_q;
  logic [CNT_W-1:0] out_ovr_q, out_ovf_q;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign fill_cut = (fill_q == LVL_W'(DEPTH)) ? LVL_W'(DEPTH - 1) : fill_q;
  assign wr_ext  = {1'b0, wr_idx_q};
  assign cut_ext = (IW + 1)'(fill_cut);
  assign rd_ext  = (wr_ext >= cut_ext) ? wr_ext - cut_ext
                                       : wr_ext + (IW + 1)'(DEPTH) - cut_ext;

  always_comb begin
    wr_idx_d = wr_idx_q;
    fill_d   = fill_q;
    peak_d   = peak_q;
    ovr_d    = ovr_q;
    ovf_d    = ovf_q;
    pop_ok   = 1'b0;
    over     = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = wr_idx_q;
    case (s_axis_tuser)
      FUNC_PUSH: begin
        ram_en   = s_acc;
        ram_we   = 1'b1;
        wr_idx_d = (wr_idx_q == IW'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
        fill_d   = (fill_q == LVL_W'(DEPTH)) ? fill_q : fill_q + 1'b1;
      end
      FUNC_POP: begin
        if (fill_q != '0) begin
          pop_ok = 1'b1;
          peak_d = (peak_q < fill_q) ? fill_q : peak_q;
          if (fill_q == LVL_W'(DEPTH)) begin
            ovf_d    = ovf_q + 1'b1;
            over     = 1'b1;
          end
          ram_en   = s_acc;
          ram_addr = rd_ext[IW-1:0];
          fill_d   = fill_cut - 1'b1;
        end
      end
      FUNC_OVERRUN: begin
        ovr_d = ovr_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  rxrb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(s_axis_tdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '0;
      fill_q      <= '0;
      peak_q      <= '0;
      ovr_q       <= '0;
      ovf_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        wr_idx_q <= wr_idx_d;
        fill_q   <= fill_d;
        peak_q   <= peak_d;
        ovr_q    <= ovr_d;
        ovf_q    <= ovf_d;
      end
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_pop_q  <= pop_ok;
      s1_over_q <= over;
      s1_fill_q <= fill_d;
      s1_peak_q <= peak_d;
      s1_ovr_q  <= ovr_d;
      s1_ovf_q  <= ovf_d;
    end
    if (s1_move) begin
      out_pop_q  <= s1_pop_q;
      out_over_q <= s1_over_q;
      out_byte_q <= s1_pop_q ? ram_rdata : '0;
      out_fill_q <= s1_fill_q;
      out_peak_q <= s1_peak_q;
      out_ovr_q  <= s1_ovr_q;
      out_ovf_q  <= s1_ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(PACK_W'({out_peak_q, out_ovf_q, out_ovr_q,
                                             out_fill_q, out_byte_q}));
  assign m_axis_tuser  = {out_over_q, out_pop_q};

endmodule

@@ rtl/core/rxrb_checker.sv @@
// rxrb_checker: port-level assertions for rx_byte_ring_buffer_overwrite
// depends on rxrb_pkg; bound to the top level below
module rxrb_checker #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned LVL_W = $clog2(DEPTH + 1),
  localparam int unsigned M_TDATA_W =
    ((rxrb_pkg::BYTE_W + 2 * rxrb_pkg::CNT_W + 2 * LVL_W + 7) / 8) * 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [7:0]                  s_axis_tdata,
  input logic [rxrb_pkg::FUNC_W-1:0] s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [M_TDATA_W-1:0]        m_axis_tdata,
  input logic [rxrb_pkg::FLAG_W-1:0] m_axis_tuser
);
  import rxrb_pkg::*;

  localparam int unsigned FILL_LO = BYTE_W;
  localparam int unsigned PEAK_LO = BYTE_W + LVL_W + 2 * CNT_W;

  logic [LVL_W-1:0] fill_lvl, peak_lvl;

  assign fill_lvl = m_axis_tdata[FILL_LO +: LVL_W];
  assign peak_lvl = m_axis_tdata[PEAK_LO +: LVL_W];

  // input only backs up behind a stalled result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output free");

  a_over_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[FLAG_OVER] |-> m_axis_tuser[FLAG_VALID])
    else $error("overflow flagged without a returned byte");

  a_levels_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> fill_lvl <= LVL_W'(DEPTH) && peak_lvl <= LVL_W'(DEPTH)
                      && (!m_axis_tuser[FLAG_VALID] || fill_lvl < peak_lvl))
    else $error("fill or peak level out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[FLAG_VALID] |-> m_axis_tdata[BYTE_W-1:0] == '0)
    else $error("byte present without a valid pop");

endmodule

bind rx_byte_ring_buffer_overwrite rxrb_checker #(.DEPTH(DEPTH)) u_rxrb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

@@ verif/testbench.sv @@
// testbench for rx_byte_ring_buffer_overwrite: stream stimulus, random idling and a
// scoreboard that tracks byte store, fill, peak and both event counters
// depends on rxrb_pkg and the ring buffer rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rxrb_pkg::*;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);
  localparam int unsigned M_TDATA_W = ((BYTE_W + 2 * CNT_W + 2 * LVL_W + 7) / 8) * 8;
  localparam int unsigned FILL_LSB = BYTE_W;
  localparam int unsigned OVRN_LSB = FILL_LSB + LVL_W;
  localparam int unsigned OVFL_LSB = OVRN_LSB + CNT_W;
  localparam int unsigned PEAK_LSB = OVFL_LSB + CNT_W;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic             data_valid;
    logic [7:0]       data_byte;
    logic             overflowed;
    logic [LVL_W-1:0] fill_level;
    logic [31:0]      overrun_errors;
    logic [31:0]      overflow_events;
    logic [LVL_W-1:0] max_fill;
  } ring_result_t;

  class rx_ring_scoreboard;
    logic [7:0]       byte_mem [DEPTH];
    logic [IDX_W-1:0] wr_idx;
    logic [LVL_W-1:0] fill;
    logic [LVL_W-1:0] peak;
    logic [31:0]      overruns;
    logic [31:0]      overflows;
    ring_result_t     pending_results [$];
    int               errors;
    int               requests;
    int               checked;
    int               overflow_pops;

    function new();
      wr_idx = '0;
      fill = '0;
      peak = '0;
      overruns = '0;
      overflows = '0;
      errors = 0;
      requests = 0;
      checked = 0;
      overflow_pops = 0;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [7:0] rx_byte);
      ring_result_t     r;
      logic [IDX_W-1:0] rd_idx;
      r = '0;
      requests++;
      case (func)
        FUNC_PUSH: begin
          byte_mem[wr_idx] = rx_byte;
          wr_idx = wr_idx + 1'b1;
          if (fill < DEPTH) fill = fill + 1'b1;
        end
        FUNC_POP: begin
          if (fill != 0) begin
            if (peak < fill) peak = fill;
            if (fill >= DEPTH) begin
              fill = LVL_W'(DEPTH - 1);
              overflows = overflows + 1;
              r.overflowed = 1'b1;
              overflow_pops++;
            end
            rd_idx = wr_idx - fill[IDX_W-1:0];
            r.data_byte = byte_mem[rd_idx];
            r.data_valid = 1'b1;
            fill = fill - 1'b1;
          end
        end
        FUNC_OVERRUN: overruns = overruns + 1;
        default: ;
      endcase
      r.fill_level = fill;
      r.overrun_errors = overruns;
      r.overflow_events = overflows;
      r.max_fill = peak;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [FLAG_W-1:0] tuser);
      ring_result_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      compare_field("data_valid", 32'(exp_r.data_valid), 32'(tuser[FLAG_VALID]));
      compare_field("overflowed", 32'(exp_r.overflowed), 32'(tuser[FLAG_OVER]));
      compare_field("data_byte", 32'(exp_r.data_byte), 32'(tdata[0 +: BYTE_W]));
      compare_field("fill_level", 32'(exp_r.fill_level), 32'(tdata[FILL_LSB +: LVL_W]));
      compare_field("overrun_errors", exp_r.overrun_errors, tdata[OVRN_LSB +: CNT_W]);
      compare_field("overflow_events", exp_r.overflow_events, tdata[OVFL_LSB +: CNT_W]);
      compare_field("max_fill", 32'(exp_r.max_fill), 32'(tdata[PEAK_LSB +: LVL_W]));
      compare_field("tdata padding", 32'd0, 32'(tdata[M_TDATA_W-1:PEAK_LSB+LVL_W]));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // rx_byte
  logic [FUNC_W-1:0]     s_axis_tuser;   // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // data_byte, fill_level, overrun_errors, overflow_events, max_fill
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [FLAG_W-1:0]     m_axis_tuser;   // data_valid, overflowed

  rx_ring_scoreboard board;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off_req;

  rx_byte_ring_buffer_overwrite #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side, with one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: done, errors");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [7:0] rx_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= rx_byte;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(func, rx_byte);
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // bursts of pushes and pops with some overrun events and unused selectors
  task automatic run_traffic(input int n_items);
    int done_cnt;
    int pick;
    int len;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      pick = $urandom_range(99);
      len = $urandom_range(1, 16);
      if (pick < 45) begin
        repeat (len) send_request(FUNC_PUSH, 8'($urandom));
        done_cnt += len;
      end else if (pick < 90) begin
        repeat (len) send_request(FUNC_POP, 8'($urandom));
        done_cnt += len;
      end else if (pick < 96) begin
        send_request(FUNC_OVERRUN, 8'($urandom));
        done_cnt++;
      end else begin
        send_request(FUNC_UNUSED, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_PUSH;
    hold_off_req  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    board = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty pops, unused selector, byte extremes
    send_request(FUNC_POP, 8'h00);
    send_request(FUNC_UNUSED, 8'hff);
    send_request(FUNC_OVERRUN, 8'h00);
    send_request(FUNC_PUSH, 8'h00);
    send_request(FUNC_PUSH, 8'hff);
    send_request(FUNC_PUSH, 8'ha5);
    send_request(FUNC_PUSH, 8'h5a);
    send_request(FUNC_UNUSED, 8'h00);
    send_request(FUNC_POP, 8'hff);
    send_request(FUNC_POP, 8'h00);
    send_request(FUNC_OVERRUN, 8'hff);
    send_request(FUNC_PUSH, 8'h01);
    send_request(FUNC_PUSH, 8'h80);
    send_request(FUNC_POP, 8'h00);
    send_request(FUNC_POP, 8'h00);
    send_request(FUNC_POP, 8'h00);
    send_request(FUNC_POP, 8'h00);
    send_request(FUNC_POP, 8'h00);

    set_idling(0, 0);
    run_traffic(170);
    set_idling(54, 0);
    run_traffic(170);
    set_idling(0, 54);
    run_traffic(170);
    set_idling(7, 7);
    run_traffic(170);

    // receiver holds off while requests keep coming
    set_idling(0, 0);
    hold_off_req = 1'b1;
    run_traffic(60);

    set_idling(54, 54);
    run_traffic(50);

    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("summary: %0d requests, %0d results checked, %0d overflowing pops",
             board.requests, board.checked, board.overflow_pops);
    $display("summary: peak fill %0d, %0d overrun events, idle and hold-off phases run",
             board.peak, board.overruns);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
